[design/mbe_pkg.sv]
package mbe_pkg;

    // Default parameter values
    localparam int MBE_MAX_DIM   = 1024;
    localparam int MBE_FRAC_BITS = 28;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int DIM_W   = 11;
    localparam int ITER_W  = 16;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 17;
    localparam int PIX_W   = 20;
    localparam int CFG_AW  = 3;

    // Step divider: |x_max - x_min| fits 32 bits, the sign travels apart
    localparam int QUO_W     = 32;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_X_MIN     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_X_MAX     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_Y_MIN     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_Y_MAX     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ROWS      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_COLS      = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MAX_ITERS = 3'd6;

    // Request into the step divider
    typedef struct packed {
        logic                       go;
        logic signed [COORD_W:0]    dividend;
        logic        [DIM_W-1:0]    divisor;
    } t_div_req;

    // Status back from the step divider
    typedef struct packed {
        logic                       busy;
        logic                       done;
        logic signed [QUO_W:0]      quotient;
    } t_div_rsp;

endpackage

[design/mbe_div.sv]
module mbe_div
    import mbe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QUO_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_div;
    logic                 r_neg;

    logic [QUO_W:0]       w_mag;
    logic [DIM_W:0]       w_trial;
    logic [DIM_W:0]       w_diff;
    logic                 w_ge;

    // Take magnitude of the signed dividend
    assign w_mag   = i_req.dividend[COORD_W] ? (QUO_W+1)'(-i_req.dividend)
                                             : (QUO_W+1)'(i_req.dividend);

    // One restoring step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // Control: count one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_quo <= w_mag[QUO_W-1:0];
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_neg <= i_req.dividend[COORD_W];
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
        end
    end

    // Restore sign: truncation toward zero
    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

[design/mandelbrot_escape_time.sv]
// Mandelbrot escape-time evaluator for one pixel per request.
//
// Request channel: drive i_row/i_col with i_start; the request is taken at a
// clock edge where i_start is high and o_busy is low. o_busy stays high until
// the result has been issued.
// Result channel: o_done pulses for one cycle with o_escape_count (-1 when
// the iteration limit is reached) and o_pixel_index (row*cols+col, low 20
// bits). The receiver cannot stall; o_done marks a result for that cycle only.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once.
// Write only while o_busy is low.
// Sequence: two step divisions, x then y, on the shared divider, two setup
// steps (offset products, then the point c), then a square step and an update
// step per escape iteration on the complex-square unit, until the escape
// test holds or the count reaches max_iters. One request at a time; the next
// may start in the cycle of o_done.
// Reset (synchronous, active low) restores the default window -2..1 by -1..1,
// a 64x64 image and 256 iterations, and drops any request in flight.
module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int MAX_DIM   = MBE_MAX_DIM,
    parameter int FRAC_BITS = MBE_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [IDX_W-1:0]          i_row,
    input  logic [IDX_W-1:0]          i_col,
    output logic                      o_busy,
    output logic                      o_done,
    output logic signed [CNT_W-1:0]   o_escape_count,
    output logic [PIX_W-1:0]          o_pixel_index,
    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_idx,
    input  logic [COORD_W-1:0]        i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVX = 3'd1;
    localparam logic [2:0] S_DIVY = 3'd2;
    localparam logic [2:0] S_MULC = 3'd3;
    localparam logic [2:0] S_ADDC = 3'd4;
    localparam logic [2:0] S_SQR  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;

    localparam logic signed [63:0] FOUR  = 64'sd4 <<< FRAC_BITS;
    localparam logic signed [63:0] Q_HI  = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO  = -64'sd2147483648;

    // Configuration registers
    logic signed [COORD_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [DIM_W-1:0]          r_rows, r_cols;
    logic [ITER_W-1:0]         r_max_iters;

    // Sequencer and datapath registers
    logic [2:0]                r_state, n_state;
    logic [IDX_W-1:0]          r_row, r_col;
    logic signed [COORD_W:0]   r_dx, r_dy;
    logic signed [43:0]        r_px, r_py;
    logic [PIX_W-1:0]          r_pix;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_zx, r_zy;
    logic signed [63:0]        r_pxx, r_pyy, r_pxy;
    logic [ITER_W-1:0]         r_n;
    logic                      r_done;
    logic signed [CNT_W-1:0]   r_escape_count;
    logic [PIX_W-1:0]          r_pixel_index;

    logic                      w_accept;
    logic [DIM_W-1:0]          w_nr, w_nc;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;
    logic signed [43:0]        w_px, w_py;
    logic [20:0]               w_pix_full;
    logic signed [63:0]        w_cx_sum, w_cy_sum;
    logic signed [63:0]        w_xx, w_yy, w_xy2;
    logic                      w_escape;
    logic signed [63:0]        w_zx_sum, w_zy_sum;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > Q_HI) begin
            res = Q_HI[COORD_W-1:0];
        end else if (v < Q_LO) begin
            res = Q_LO[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    assign w_accept = i_start && (r_state == S_IDLE);

    // Clamp image dimensions to the supported maximum
    assign w_nr = (32'(r_rows) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_rows;
    assign w_nc = (32'(r_cols) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cols;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min     <= -32'sd536870912;
            r_x_max     <= 32'sd268435456;
            r_y_min     <= -32'sd268435456;
            r_y_max     <= 32'sd268435456;
            r_rows      <= DIM_W'(64);
            r_cols      <= DIM_W'(64);
            r_max_iters <= ITER_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_MIN:     r_x_min     <= i_cfg_data;
                REG_X_MAX:     r_x_max     <= i_cfg_data;
                REG_Y_MIN:     r_y_min     <= i_cfg_data;
                REG_Y_MAX:     r_y_max     <= i_cfg_data;
                REG_ROWS:      r_rows      <= i_cfg_data[DIM_W-1:0];
                REG_COLS:      r_cols      <= i_cfg_data[DIM_W-1:0];
                REG_MAX_ITERS: r_max_iters <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Issue step divisions: x on accept, y when x finishes
    always_comb begin
        w_div_req.go = w_accept || ((r_state == S_DIVX) && w_div_rsp.done);
        if (r_state == S_IDLE) begin
            w_div_req.dividend = (COORD_W+1)'(r_x_max) - (COORD_W+1)'(r_x_min);
            w_div_req.divisor  = w_nc - 1'b1;
        end else begin
            w_div_req.dividend = (COORD_W+1)'(r_y_max) - (COORD_W+1)'(r_y_min);
            w_div_req.divisor  = w_nr - 1'b1;
        end
    end

    mbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Map pixel offsets into the window
    assign w_px       = $signed({1'b0, r_col}) * r_dx;
    assign w_py       = $signed({1'b0, r_row}) * r_dy;
    assign w_pix_full = 21'(r_row) * 21'(w_nc) + 21'(r_col);
    assign w_cx_sum   = 64'(r_x_min) + 64'(r_px);
    assign w_cy_sum   = 64'(r_y_min) + 64'(r_py);

    // Combine registered products: escape test and next z
    assign w_xx     = r_pxx >>> FRAC_BITS;
    assign w_yy     = r_pyy >>> FRAC_BITS;
    assign w_xy2    = r_pxy >>> (FRAC_BITS - 1);
    assign w_escape = (w_xx + w_yy) >= FOUR;
    assign w_zx_sum = w_xx - w_yy + 64'(r_cx);
    assign w_zy_sum = w_xy2 + 64'(r_cy);

    // Sequence one pixel
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_DIVX;
            S_DIVX: if (w_div_rsp.done) n_state = S_DIVY;
            S_DIVY: if (w_div_rsp.done) n_state = S_MULC;
            S_MULC: n_state = S_ADDC;
            S_ADDC: n_state = S_SQR;
            S_SQR:  n_state = S_UPD;
            S_UPD: begin
                if ((r_n == r_max_iters) || w_escape) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SQR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_UPD) && (n_state == S_IDLE);
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if ((r_state == S_DIVX) && w_div_rsp.done) begin
            r_dx <= (w_nc < DIM_W'(2)) ? '0 : w_div_rsp.quotient;
        end
        if ((r_state == S_DIVY) && w_div_rsp.done) begin
            r_dy <= (w_nr < DIM_W'(2)) ? '0 : w_div_rsp.quotient;
        end
        if (r_state == S_MULC) begin
            r_px  <= w_px;
            r_py  <= w_py;
            r_pix <= w_pix_full[PIX_W-1:0];
        end
        if (r_state == S_ADDC) begin
            r_cx <= sat32(w_cx_sum);
            r_cy <= sat32(w_cy_sum);
            r_zx <= '0;
            r_zy <= '0;
            r_n  <= '0;
        end
        if (r_state == S_SQR) begin
            r_pxx <= r_zx * r_zx;
            r_pyy <= r_zy * r_zy;
            r_pxy <= r_zx * r_zy;
        end
        if (r_state == S_UPD) begin
            r_zx <= sat32(w_zx_sum);
            r_zy <= sat32(w_zy_sum);
            r_n  <= r_n + 1'b1;
            if (r_n == r_max_iters) begin
                r_escape_count <= -17'sd1;
            end else begin
                r_escape_count <= $signed({1'b0, r_n});
            end
            r_pixel_index <= r_pix;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_escape_count = r_escape_count;
    assign o_pixel_index  = r_pixel_index;

    // A result only follows the final update step
    a_done_after_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_UPD))
        else $error("result strobe without a final update");

    // The divider is never restarted while running
    a_div_idle_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.go |-> !w_div_rsp.busy)
        else $error("divider request while busy");

    // The iteration count never passes the limit
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_n <= r_max_iters))
        else $error("iteration count beyond limit");

    // An escaped count lies below the limit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_escape_count != -17'sd1)) |->
            (o_escape_count[ITER_W-1:0] < r_max_iters))
        else $error("escape count not below limit");

endmodule
